// ----- hdl/mbl_pkg.sv -----
// shared constants and types for the weighted pixel blend
`default_nettype none
package mbl_pkg;

	localparam int IMG_COUNT       = 4;
	localparam int CHAN_COUNT      = 3;
	localparam int CHAN_BITS       = 8;
	localparam int PIX_BITS        = CHAN_COUNT * CHAN_BITS;
	localparam int CNT_BITS        = 3;
	localparam int IDX_BITS        = $clog2(IMG_COUNT);
	localparam int Q_BITS          = CHAN_BITS;
	localparam int WEIGHT_BITS_DEF = 16;

	typedef logic [CHAN_BITS-1:0] chan_t;
	typedef logic [PIX_BITS-1:0]  pix_t;
	typedef logic [CNT_BITS-1:0]  count_t;

	typedef struct packed {
		logic   use_div;
		pix_t   fallback;
		count_t count;
	} blend_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/mbl_front.sv -----
// presence detection, weighted products and sums ahead of the divider
`default_nettype none
module mbl_front
	import mbl_pkg::*;
#(
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
	localparam int PROD_W = WEIGHT_BITS + CHAN_BITS,
	localparam int ACC_W  = PROD_W + IDX_BITS,
	localparam int WSUM_W = WEIGHT_BITS + IDX_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   up_valid,
	output logic                        up_stall,
	input  wire pix_t                   pixels [IMG_COUNT],
	input  wire logic [WEIGHT_BITS-1:0] weights [IMG_COUNT],
	output logic                        dn_valid,
	input  wire logic                   dn_stall,
	output logic [ACC_W-1:0]            acc [CHAN_COUNT],
	output logic [WSUM_W-1:0]           wsum,
	output blend_ctl_t                  ctl
);

	logic [IMG_COUNT-1:0]   present;
	logic [IDX_BITS-1:0]    first;
	logic                   found;
	count_t                 cnt;
	logic [PROD_W-1:0]      prod [IMG_COUNT][CHAN_COUNT];
	logic [WEIGHT_BITS-1:0] wgt_m [IMG_COUNT];

	logic                   valid_s1;
	logic [PROD_W-1:0]      prod_s1 [IMG_COUNT][CHAN_COUNT];
	logic [WEIGHT_BITS-1:0] wgt_s1 [IMG_COUNT];
	pix_t                   fallback_s1;
	count_t                 count_s1;

	logic [ACC_W-1:0]       acc_sum [CHAN_COUNT];
	logic [WSUM_W-1:0]      wsum_sum;

	logic                   valid_s2;
	logic [ACC_W-1:0]       acc_s2 [CHAN_COUNT];
	logic [WSUM_W-1:0]      wsum_s2;
	blend_ctl_t             ctl_s2;

	logic                   stall_s1;
	logic                   stall_s2;

	assign stall_s2 = valid_s2 & dn_stall;
	assign stall_s1 = valid_s1 & stall_s2;
	assign up_stall = stall_s1;

	always_comb begin
		present = '0;
		first   = '0;
		found   = 1'b0;
		cnt     = '0;
		for (int k = 0; k < IMG_COUNT; k++) begin
			present[k] = |pixels[k];
			if (present[k] && !found) begin
				first = IDX_BITS'(k);
				found = 1'b1;
			end
			cnt = cnt + {{(CNT_BITS-1){1'b0}}, present[k]};
			wgt_m[k] = present[k] ? weights[k] : '0;
			for (int c = 0; c < CHAN_COUNT; c++) begin
				prod[k][c] = present[k] ?
					PROD_W'(weights[k]) * PROD_W'(pixels[k][c*CHAN_BITS +: CHAN_BITS]) : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_s1) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && !stall_s1) begin
			prod_s1     <= prod;
			wgt_s1      <= wgt_m;
			fallback_s1 <= pixels[first];
			count_s1    <= cnt;
		end
	end

	always_comb begin
		wsum_sum = '0;
		for (int c = 0; c < CHAN_COUNT; c++) begin
			acc_sum[c] = '0;
		end
		for (int k = 0; k < IMG_COUNT; k++) begin
			wsum_sum = wsum_sum + WSUM_W'(wgt_s1[k]);
			for (int c = 0; c < CHAN_COUNT; c++) begin
				acc_sum[c] = acc_sum[c] + ACC_W'(prod_s1[k][c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && !stall_s2) begin
			acc_s2           <= acc_sum;
			wsum_s2          <= wsum_sum;
			ctl_s2.use_div   <= (count_s1 >= CNT_BITS'(2)) && (wsum_sum != '0);
			ctl_s2.fallback  <= fallback_s1;
			ctl_s2.count     <= count_s1;
		end
	end

	assign dn_valid = valid_s2;
	assign acc      = acc_s2;
	assign wsum     = wsum_s2;
	assign ctl      = ctl_s2;

endmodule
`default_nettype wire

// ----- hdl/mbl_div_stage.sv -----
// one restoring divider stage, one quotient bit for each channel
`default_nettype none
module mbl_div_stage
	import mbl_pkg::*;
#(
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
	parameter int BIT_POS     = 0,
	localparam int ACC_W  = WEIGHT_BITS + CHAN_BITS + IDX_BITS,
	localparam int WSUM_W = WEIGHT_BITS + IDX_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              up_valid,
	output logic                   up_stall,
	input  wire logic [ACC_W-1:0]  rem_i [CHAN_COUNT],
	input  wire logic [WSUM_W-1:0] wsum_i,
	input  wire logic [Q_BITS-1:0] quo_i [CHAN_COUNT],
	input  wire blend_ctl_t        ctl_i,
	output logic                   dn_valid,
	input  wire logic              dn_stall,
	output logic [ACC_W-1:0]       rem_o [CHAN_COUNT],
	output logic [WSUM_W-1:0]      wsum_o,
	output logic [Q_BITS-1:0]      quo_o [CHAN_COUNT],
	output blend_ctl_t             ctl_o
);

	logic [ACC_W-1:0]  dvs;
	logic [ACC_W-1:0]  rem_n [CHAN_COUNT];
	logic [Q_BITS-1:0] quo_n [CHAN_COUNT];

	logic              valid_q;
	logic [ACC_W-1:0]  rem_q [CHAN_COUNT];
	logic [WSUM_W-1:0] wsum_q;
	logic [Q_BITS-1:0] quo_q [CHAN_COUNT];
	blend_ctl_t        ctl_q;

	assign up_stall = valid_q & dn_stall;
	assign dvs      = ACC_W'(wsum_i) << BIT_POS;

	always_comb begin
		for (int c = 0; c < CHAN_COUNT; c++) begin
			if (rem_i[c] >= dvs) begin
				rem_n[c] = rem_i[c] - dvs;
				quo_n[c] = quo_i[c] | (Q_BITS'(1) << BIT_POS);
			end else begin
				rem_n[c] = rem_i[c];
				quo_n[c] = quo_i[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!up_stall) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && !up_stall) begin
			rem_q  <= rem_n;
			wsum_q <= wsum_i;
			quo_q  <= quo_n;
			ctl_q  <= ctl_i;
		end
	end

	assign dn_valid = valid_q;
	assign rem_o    = rem_q;
	assign wsum_o   = wsum_q;
	assign quo_o    = quo_q;
	assign ctl_o    = ctl_q;

endmodule
`default_nettype wire

// ----- hdl/multi_image_weighted_pixel_blend_top.sv -----
// Feathered blend of four co-located pixels by distance-to-edge weight. One pixel word is taken
// every clock while pix_stall is low, and each result is held until the output side takes it:
// ten register stages in all, two to detect present images, form the weight-by-channel products
// and sum them, then eight stages of a pipelined restoring divider that settles one quotient bit
// per stage for all three channels at once. The whole pipeline halts while blend_stall holds a
// finished word, and empty stages fill up so no bubble is kept. Weights are unsigned Q12.4, with
// WEIGHT_BITS setting their width; the result is the truncated weighted mean of present pixels,
// or the lowest present pixel when under two are present or their weights sum to zero.
`default_nettype none
module multi_image_weighted_pixel_blend_top
	import mbl_pkg::*;
#(
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   pix_valid,
	output logic                        pix_stall,
	input  wire logic [PIX_BITS-1:0]    pixel_a,
	input  wire logic [PIX_BITS-1:0]    pixel_b,
	input  wire logic [PIX_BITS-1:0]    pixel_c,
	input  wire logic [PIX_BITS-1:0]    pixel_d,
	input  wire logic [WEIGHT_BITS-1:0] weight_a,
	input  wire logic [WEIGHT_BITS-1:0] weight_b,
	input  wire logic [WEIGHT_BITS-1:0] weight_c,
	input  wire logic [WEIGHT_BITS-1:0] weight_d,
	output logic                        blend_valid,
	input  wire logic                   blend_stall,
	output logic [CHAN_BITS-1:0]        out_channel_0,
	output logic [CHAN_BITS-1:0]        out_channel_1,
	output logic [CHAN_BITS-1:0]        out_channel_2,
	output logic [CNT_BITS-1:0]         overlap_count
);

	localparam int ACC_W  = WEIGHT_BITS + CHAN_BITS + IDX_BITS;
	localparam int WSUM_W = WEIGHT_BITS + IDX_BITS;

	pix_t                   pixels [IMG_COUNT];
	logic [WEIGHT_BITS-1:0] weights [IMG_COUNT];

	logic                   valid_w [Q_BITS+1];
	logic                   stall_w [Q_BITS+1];
	logic [ACC_W-1:0]       rem_w [Q_BITS+1][CHAN_COUNT];
	logic [WSUM_W-1:0]      wsum_w [Q_BITS+1];
	logic [Q_BITS-1:0]      quo_w [Q_BITS+1][CHAN_COUNT];
	blend_ctl_t             ctl_w [Q_BITS+1];

	chan_t                  chan_res [CHAN_COUNT];

	assign pixels[0]  = pixel_a;
	assign pixels[1]  = pixel_b;
	assign pixels[2]  = pixel_c;
	assign pixels[3]  = pixel_d;
	assign weights[0] = weight_a;
	assign weights[1] = weight_b;
	assign weights[2] = weight_c;
	assign weights[3] = weight_d;

	mbl_front #(
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pix_valid),
		.up_stall (pix_stall),
		.pixels   (pixels),
		.weights  (weights),
		.dn_valid (valid_w[0]),
		.dn_stall (stall_w[0]),
		.acc      (rem_w[0]),
		.wsum     (wsum_w[0]),
		.ctl      (ctl_w[0])
	);

	always_comb begin
		for (int c = 0; c < CHAN_COUNT; c++) begin
			quo_w[0][c] = '0;
		end
	end

	for (genvar j = 0; j < Q_BITS; j++) begin : g_div
		mbl_div_stage #(
			.WEIGHT_BITS (WEIGHT_BITS),
			.BIT_POS     (Q_BITS - 1 - j)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_w[j]),
			.up_stall (stall_w[j]),
			.rem_i    (rem_w[j]),
			.wsum_i   (wsum_w[j]),
			.quo_i    (quo_w[j]),
			.ctl_i    (ctl_w[j]),
			.dn_valid (valid_w[j+1]),
			.dn_stall (stall_w[j+1]),
			.rem_o    (rem_w[j+1]),
			.wsum_o   (wsum_w[j+1]),
			.quo_o    (quo_w[j+1]),
			.ctl_o    (ctl_w[j+1])
		);
	end

	assign stall_w[Q_BITS] = blend_stall;

	always_comb begin
		for (int c = 0; c < CHAN_COUNT; c++) begin
			chan_res[c] = ctl_w[Q_BITS].use_div ? quo_w[Q_BITS][c] :
				ctl_w[Q_BITS].fallback[c*CHAN_BITS +: CHAN_BITS];
		end
	end

	assign blend_valid   = valid_w[Q_BITS];
	assign out_channel_0 = chan_res[0];
	assign out_channel_1 = chan_res[1];
	assign out_channel_2 = chan_res[2];
	assign overlap_count = ctl_w[Q_BITS].count;

	// remainder of a finished division stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		blend_valid && ctl_w[Q_BITS].use_div |->
			rem_w[Q_BITS][0] < ACC_W'(wsum_w[Q_BITS]) &&
			rem_w[Q_BITS][1] < ACC_W'(wsum_w[Q_BITS]) &&
			rem_w[Q_BITS][2] < ACC_W'(wsum_w[Q_BITS]))
		else $error("divider remainder out of range");

	a_div_needs_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		blend_valid && ctl_w[Q_BITS].use_div |-> overlap_count >= CNT_BITS'(2))
		else $error("division used with fewer than two images");

	a_empty_is_black: assert property (@(posedge clk) disable iff (!arst_n)
		blend_valid && overlap_count == '0 |->
			out_channel_0 == '0 && out_channel_1 == '0 && out_channel_2 == '0)
		else $error("no image present but word not black");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		blend_valid |-> overlap_count <= CNT_BITS'(IMG_COUNT))
		else $error("overlap count above image count");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> blend_stall && blend_valid)
		else $error("input stalled without output back-pressure");

endmodule
`default_nettype wire

// ----- sim/feather_blend_monitor.sv -----
// monitor that predicts the feathered blend of each accepted word and checks every result
module feather_blend_monitor
	import mbl_pkg::*;
#(
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   pix_valid,
	input  wire logic                   pix_stall,
	input  wire logic [PIX_BITS-1:0]    pixel_a,
	input  wire logic [PIX_BITS-1:0]    pixel_b,
	input  wire logic [PIX_BITS-1:0]    pixel_c,
	input  wire logic [PIX_BITS-1:0]    pixel_d,
	input  wire logic [WEIGHT_BITS-1:0] weight_a,
	input  wire logic [WEIGHT_BITS-1:0] weight_b,
	input  wire logic [WEIGHT_BITS-1:0] weight_c,
	input  wire logic [WEIGHT_BITS-1:0] weight_d,
	input  wire logic                   blend_valid,
	input  wire logic                   blend_stall,
	input  wire logic [CHAN_BITS-1:0]   out_channel_0,
	input  wire logic [CHAN_BITS-1:0]   out_channel_1,
	input  wire logic [CHAN_BITS-1:0]   out_channel_2,
	input  wire logic [CNT_BITS-1:0]    overlap_count,
	output int                          mismatches,
	output int                          outstanding,
	output int                          compared
);

	typedef logic [IMG_COUNT-1:0][PIX_BITS-1:0]    pix_set_t;
	typedef logic [IMG_COUNT-1:0][WEIGHT_BITS-1:0] weight_set_t;

	typedef struct packed {
		chan_t [CHAN_COUNT-1:0] chan;
		count_t                 present;
	} blend_word_t;

	blend_word_t expected_pixels [$];

	function automatic blend_word_t feather_mean(input pix_set_t pix, input weight_set_t wgt);
		blend_word_t     r;
		longint unsigned acc [CHAN_COUNT];
		longint unsigned wsum;
		int unsigned     present;
		int              first;
		r = '0;
		wsum = 0;
		present = 0;
		first = -1;
		for (int c = 0; c < CHAN_COUNT; c++)
			acc[c] = 0;
		for (int k = 0; k < IMG_COUNT; k++) begin
			// an all-zero pixel means the image does not cover this position
			if (pix[k] != '0) begin
				present++;
				if (first < 0)
					first = k;
				wsum += 64'(wgt[k]);
				for (int c = 0; c < CHAN_COUNT; c++)
					acc[c] += 64'(wgt[k]) * 64'(pix[k][c*CHAN_BITS +: CHAN_BITS]);
			end
		end
		for (int c = 0; c < CHAN_COUNT; c++) begin
			if (present == 0)
				r.chan[c] = '0;
			else if (present == 1 || wsum == 0)
				r.chan[c] = pix[first][c*CHAN_BITS +: CHAN_BITS];
			else
				r.chan[c] = chan_t'(acc[c] / wsum);
		end
		r.present = count_t'(present);
		return r;
	endfunction

	always @(posedge clk) begin
		blend_word_t got;
		blend_word_t want;
		if (arst_n) begin
			if (pix_valid && !pix_stall)
				expected_pixels.insert(expected_pixels.size(),
					feather_mean({pixel_d, pixel_c, pixel_b, pixel_a},
					{weight_d, weight_c, weight_b, weight_a}));
			if (blend_valid && !blend_stall) begin
				got = {out_channel_2, out_channel_1, out_channel_0, overlap_count};
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: blend word %h %h %h count %0d with none expected", $time,
							got.chan[0], got.chan[1], got.chan[2], got.present);
				end else begin
					want = expected_pixels.pop_front();
					compared++;
					if (got.chan[0] !== want.chan[0] || got.chan[1] !== want.chan[1] ||
							got.chan[2] !== want.chan[2] || got.present !== want.present) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: word %0d expected %h %h %h count %0d, got %h %h %h count %0d",
								$time, compared, want.chan[0], want.chan[1], want.chan[2],
								want.present, got.chan[0], got.chan[1], got.chan[2], got.present);
					end
				end
			end
			outstanding = expected_pixels.size();
		end
	end

endmodule

// ----- sim/multi_image_weighted_pixel_blend_top_tb.sv -----
// testbench top: drives pixel words and stalls, and gives the verdict of the blend monitor
module multi_image_weighted_pixel_blend_top_tb;
	import mbl_pkg::*;

	localparam int WB = WEIGHT_BITS_DEF;

	typedef logic [IMG_COUNT-1:0][PIX_BITS-1:0] pix_set_t;
	typedef logic [IMG_COUNT-1:0][WB-1:0]       weight_set_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 pix_valid   = 1'b0;
	logic                 blend_stall = 1'b0;
	logic [PIX_BITS-1:0]  pixel_a     = '0;
	logic [PIX_BITS-1:0]  pixel_b     = '0;
	logic [PIX_BITS-1:0]  pixel_c     = '0;
	logic [PIX_BITS-1:0]  pixel_d     = '0;
	logic [WB-1:0]        weight_a    = '0;
	logic [WB-1:0]        weight_b    = '0;
	logic [WB-1:0]        weight_c    = '0;
	logic [WB-1:0]        weight_d    = '0;
	wire                  pix_stall;
	wire                  blend_valid;
	wire [CHAN_BITS-1:0]  out_channel_0;
	wire [CHAN_BITS-1:0]  out_channel_1;
	wire [CHAN_BITS-1:0]  out_channel_2;
	wire [CNT_BITS-1:0]   overlap_count;

	int mismatches;
	int outstanding;
	int compared;
	int words_sent;
	int directed_words;
	int results_taken;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	multi_image_weighted_pixel_blend_top #(.WEIGHT_BITS(WB)) dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall),
		.pixel_a(pixel_a), .pixel_b(pixel_b), .pixel_c(pixel_c), .pixel_d(pixel_d),
		.weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c), .weight_d(weight_d),
		.blend_valid(blend_valid), .blend_stall(blend_stall),
		.out_channel_0(out_channel_0), .out_channel_1(out_channel_1),
		.out_channel_2(out_channel_2), .overlap_count(overlap_count)
	);

	feather_blend_monitor #(.WEIGHT_BITS(WB)) monitor (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall),
		.pixel_a(pixel_a), .pixel_b(pixel_b), .pixel_c(pixel_c), .pixel_d(pixel_d),
		.weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c), .weight_d(weight_d),
		.blend_valid(blend_valid), .blend_stall(blend_stall),
		.out_channel_0(out_channel_0), .out_channel_1(out_channel_1),
		.out_channel_2(out_channel_2), .overlap_count(overlap_count),
		.mismatches(mismatches), .outstanding(outstanding), .compared(compared)
	);

	function automatic int draw_wait(input bit quiet);
		return quiet ? 0 : int'($urandom_range(0, 17));
	endfunction

	task automatic send_word(input pix_set_t p, input weight_set_t w);
		int gap;
		gap = draw_wait((words_sent / 150) % 4 == 1);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pixel_a   <= p[0];
		pixel_b   <= p[1];
		pixel_c   <= p[2];
		pixel_d   <= p[3];
		weight_a  <= w[0];
		weight_b  <= w[1];
		weight_c  <= w[2];
		weight_d  <= w[3];
		do @(posedge clk); while (pix_stall);
		words_sent++;
	endtask

	// receiving side
	initial begin
		int hold;
		wait (arst_n);
		forever begin
			hold = draw_wait((results_taken / 200) % 3 == 2);
			if (hold > 0) begin
				blend_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				blend_stall <= 1'b0;
			end
			do @(posedge clk); while (!blend_valid);
			results_taken++;
		end
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		pix_set_t    p;
		weight_set_t w;
		int          style;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing present, with and without weights
		send_word({24'h000000, 24'h000000, 24'h000000, 24'h000000},
			{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_word('0, '0);
		// a single image present passes through whatever its weight
		send_word({24'h000000, 24'h000000, 24'h000000, 24'hFFFFFF},
			{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000});
		send_word({24'h000000, 24'h000000, 24'hFFFFFF, 24'h000000},
			{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF});
		send_word({24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000},
			{16'h0000, 16'hFFFF, 16'h0000, 16'h0000});
		send_word({24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000},
			{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF});
		send_word({24'h000000, 24'h000000, 24'h000000, 24'h000001},
			{16'h0000, 16'h0000, 16'h0000, 16'hFFFF});
		// full overlap at the extremes
		send_word({24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
			{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		send_word({24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF},
			{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		// zero summed weight falls back to the lowest present image
		send_word({24'hABCDEF, 24'h000000, 24'h123456, 24'h000000},
			{16'h0000, 16'h0000, 16'h0000, 16'hFFFF});
		send_word({24'h0A0B0C, 24'h010203, 24'h7F7F7F, 24'h800001},
			{16'h0000, 16'h0000, 16'h0000, 16'h0000});
		// uneven present weights; in the first word one is zero and the other carries the blend
		send_word({24'h000000, 24'h000000, 24'hFF0000, 24'h0000FF},
			{16'hFFFF, 16'hFFFF, 16'h0010, 16'h0000});
		send_word({24'h000000, 24'h000000, 24'h000001, 24'hFFFFFF},
			{16'h0000, 16'h0000, 16'hFFFF, 16'h0001});
		send_word({24'h020202, 24'h010101, 24'h000000, 24'h030303},
			{16'h0010, 16'h0010, 16'hFFFF, 16'h0010});
		send_word({24'hFFFFFF, 24'h000080, 24'h008000, 24'h800000},
			{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF});
		// truncation of the weighted mean, then an empty word with a lone weight
		send_word({24'h000000, 24'h000000, 24'h000002, 24'h000001},
			{16'h0000, 16'h0000, 16'h0001, 16'h0001});
		send_word({24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA},
			{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
		send_word({24'h000000, 24'h000000, 24'h000000, 24'h000000},
			{16'h0001, 16'h0000, 16'h0000, 16'h0000});
		directed_words = words_sent;

		for (int i = 0; i < 2000; i++) begin
			style = $urandom_range(0, 19);
			for (int k = 0; k < IMG_COUNT; k++) begin
				case ($urandom_range(0, 7))
					0, 1: p[k] = '0;
					2: p[k] = '1;
					3: p[k] = PIX_BITS'(1) << $urandom_range(0, PIX_BITS - 1);
					default: p[k] = PIX_BITS'($urandom);
				endcase
				case ($urandom_range(0, 7))
					0: w[k] = '0;
					1: w[k] = '1;
					2: w[k] = WB'($urandom_range(0, 31));
					default: w[k] = WB'($urandom);
				endcase
			end
			if (style == 0) begin
				w = '0;
			end else if (style == 1) begin
				for (int k = 0; k < IMG_COUNT; k++) begin
					p[k] = PIX_BITS'($urandom);
					w[k] = WB'($urandom);
				end
			end
			send_word(p, w);
			if (i == 1000) begin
				// hold off until the pipeline has drained
				pix_valid <= 1'b0;
				@(posedge clk);
				wait (outstanding == 0);
			end
		end
		pix_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (30) @(posedge clk);

		$display("blend run: %0d pixel words sent (%0d directed), %0d blended words compared",
			words_sent, directed_words, compared);
		$display("random gaps and output stalls of up to 17 cycles, quiet stretches, one drain");
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
